### src/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg - shared types, constants and crc functions of the record framer
//
// Holds the framing constants, the burst type handed from the framing engine
// to the byte serializer, and the crc-8 helpers (poly 0x31, msb first).
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

   // framing constants
   localparam logic [7:0] SYNC_HI     = 8'hAA;
   localparam logic [7:0] SYNC_LO     = 8'h55;
   localparam logic [7:0] CRC_POLY    = 8'h31;
   localparam logic [7:0] CRC_INIT    = 8'hFF;
   localparam logic [7:0] MAX_PAYLOAD = 8'd255;

   // request kinds
   localparam logic REQ_HEADER  = 1'b0;
   localparam logic REQ_PAYLOAD = 1'b1;

   // a header burst: sync pair, type, eight timestamp bytes, optional crc
   localparam int BURST_MAX   = 12;
   localparam int BURST_CNT_W = 4;
   localparam int HDR_BITS    = 72;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [BURST_MAX-1:0]      eor;
      logic [BURST_CNT_W-1:0]    count;
   } srf_burst_type;

   typedef logic [7:0][HDR_BITS-1:0] srf_hdr_mask_type;

   // bit-serial crc over the header message, bit 71 first (elaboration only)
   function automatic logic [7:0] crc_serial(input logic [7:0] init,
                                             input logic [HDR_BITS-1:0] msg);
      logic [7:0] c;
      logic       fb;
      c = init;
      for (int k = HDR_BITS - 1; k >= 0; k--) begin
         fb = c[7] ^ msg[k];
         c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   // per crc bit, the set of message bits that feed it
   function automatic srf_hdr_mask_type hdr_masks();
      srf_hdr_mask_type m;
      logic [7:0]       col;
      m = '0;
      for (int k = 0; k < HDR_BITS; k++) begin
         col = crc_serial(8'h00, HDR_BITS'(1) << k);
         for (int j = 0; j < 8; j++) begin
            m[j][k] = col[j];
         end
      end
      return m;
   endfunction

   localparam srf_hdr_mask_type HDR_MASK = hdr_masks();
   localparam logic [7:0]       HDR_BASE = crc_serial(CRC_INIT, '0);

   // header crc as a parity network: one xor tree per crc bit
   function automatic logic [7:0] hdr_crc(input logic [HDR_BITS-1:0] msg);
      logic [7:0] c;
      for (int j = 0; j < 8; j++) begin
         c[j] = HDR_BASE[j] ^ (^(msg & HDR_MASK[j]));
      end
      return c;
   endfunction

   // fold one byte into the running crc
   function automatic logic [7:0] crc_fold(input logic [7:0] crc,
                                           input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### src/srf_engine.sv
// ----------------------------------------------------------------------------
// srf_engine - input register and record framing logic
//
// Registers each request word, then in one pass builds the burst of output
// bytes it causes and updates the record state (open flag, payload count,
// running crc). A word leaves the input register once the serializer can take
// its burst, or at once if it causes no bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [7:0]            req_rec_type,
   input  wire logic [63:0]           req_timestamp,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_last,
   input  wire logic                  burst_ready,
   output logic                       burst_load,
   output srf_pkg::srf_burst_type     burst
);
   import srf_pkg::*;

   logic        hold_valid_ff, hold_valid_in;
   logic        hold_type_ff;
   logic [7:0]  hold_rec_type_ff;
   logic [63:0] hold_timestamp_ff;
   logic [7:0]  hold_data_ff;
   logic        hold_last_ff;

   logic        open_ff, open_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;

   logic                consume;
   logic                take;
   logic [HDR_BITS-1:0] hdr_msg;
   logic [7:0]          hdr_crc_val;
   logic                keep;
   logic [7:0]          pay_crc;

   // header message: type, then timestamp least significant byte first
   always_comb begin
      hdr_msg[HDR_BITS-1 -: 8] = hold_rec_type_ff;
      for (int i = 0; i < 8; i++) begin
         hdr_msg[63 - 8*i -: 8] = hold_timestamp_ff[8*i +: 8];
      end
   end

   assign hdr_crc_val = hdr_crc(hdr_msg);
   assign keep        = (count_ff < MAX_PAYLOAD);
   assign pay_crc     = keep ? crc_fold(crc_ff, hold_data_ff) : crc_ff;

   // burst and next record state
   always_comb begin
      burst    = '0;
      open_in  = open_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      if (hold_type_ff == REQ_HEADER) begin
         burst.bytes[0] = SYNC_HI;
         burst.bytes[1] = SYNC_LO;
         burst.bytes[2] = hold_rec_type_ff;
         for (int i = 0; i < 8; i++) begin
            burst.bytes[3 + i] = hold_timestamp_ff[8*i +: 8];
         end
         burst.bytes[11] = hdr_crc_val;
         burst.eor[11]   = hold_last_ff;
         burst.count     = hold_last_ff ? BURST_CNT_W'(12) : BURST_CNT_W'(11);
         open_in         = !hold_last_ff;
         count_in        = '0;
         crc_in          = hold_last_ff ? CRC_INIT : hdr_crc_val;
      end else if (open_ff) begin
         // payload byte if room is left, then crc byte on last
         burst.bytes[0] = keep ? hold_data_ff : pay_crc;
         burst.bytes[1] = pay_crc;
         burst.eor[0]   = !keep && hold_last_ff;
         burst.eor[1]   = keep && hold_last_ff;
         burst.count    = BURST_CNT_W'(keep) + BURST_CNT_W'(hold_last_ff);
         if (hold_last_ff) begin
            open_in  = 1'b0;
            count_in = '0;
            crc_in   = CRC_INIT;
         end else begin
            count_in = 8'(count_ff + 8'(keep));
            crc_in   = pay_crc;
         end
      end
   end

   // handshake of the input register
   assign consume    = hold_valid_ff && ((burst.count == '0) || burst_ready);
   assign burst_load = consume && (burst.count != '0);
   assign req_stall  = hold_valid_ff && !consume;
   assign take       = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (!req_stall) begin
         hold_valid_in = req_valid;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         open_ff       <= 1'b0;
         count_ff      <= '0;
         crc_ff        <= CRC_INIT;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (consume) begin
            open_ff  <= open_in;
            count_ff <= count_in;
            crc_ff   <= crc_in;
         end
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (take) begin
         hold_type_ff      <= req_type;
         hold_rec_type_ff  <= req_rec_type;
         hold_timestamp_ff <= req_timestamp;
         hold_data_ff      <= req_data_byte;
         hold_last_ff      <= req_last;
      end
   end

endmodule

`default_nettype wire

### src/srf_serializer.sv
// ----------------------------------------------------------------------------
// srf_serializer - burst buffer and output word register
//
// Holds one burst of up to twelve bytes and shifts it out one byte per cycle,
// while rsp_stall allows, into the output register. A new burst is taken when
// the buffer is empty or its last byte moves out in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_serializer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  burst_load,
   input  wire srf_pkg::srf_burst_type burst,
   output logic                       burst_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_end_of_record
);
   import srf_pkg::*;

   srf_burst_type buf_ff, buf_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff;
   logic          out_eor_ff;
   logic          move;

   // a byte moves when one is buffered and the output register frees up
   assign move        = (buf_ff.count != '0) && (!out_valid_ff || !rsp_stall);
   assign burst_ready = (buf_ff.count == '0) ||
                        ((buf_ff.count == BURST_CNT_W'(1)) && move);

   // buffer next value: load a new burst or shift down by one byte
   always_comb begin
      buf_in = buf_ff;
      if (burst_load) begin
         buf_in = burst;
      end else if (move) begin
         for (int i = 0; i < BURST_MAX - 1; i++) begin
            buf_in.bytes[i] = buf_ff.bytes[i + 1];
            buf_in.eor[i]   = buf_ff.eor[i + 1];
         end
         buf_in.count = BURST_CNT_W'(buf_ff.count - BURST_CNT_W'(1));
      end
   end

   // output valid next value
   always_comb begin
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control state, buffer bytes and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff.count <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_ff.count <= buf_in.count;
         out_valid_ff <= out_valid_in;
      end
      buf_ff.bytes <= buf_in.bytes;
      buf_ff.eor   <= buf_in.eor;
      if (move) begin
         out_byte_ff <= buf_ff.bytes[0];
         out_eor_ff  <= buf_ff.eor[0];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_end_of_record = out_eor_ff;

endmodule

`default_nettype wire

### src/sync_record_framer_crc8.sv
// ----------------------------------------------------------------------------
// sync_record_framer_crc8 - log record framer with crc-8 trailer
//
// Turns header and payload words into a byte stream of framed records.
// ----------------------------------------------------------------------------
// A header word (req_type 0) sends 0xAA 0x55, the record type and the eight
// timestamp bytes, least significant first, and opens a record; a payload
// word (req_type 1) sends its byte. A word with req_last set also sends the
// crc-8 byte (poly 0x31, init 0xFF, msb first, over type, timestamp and
// payload) flagged by rsp_end_of_record and closes the record. Payload words
// with no open record are dropped; bytes past 255 per record are dropped but
// a dropped last word still closes the record; a header abandons any open
// record. The output runs at one byte per cycle while rsp_stall is low: a
// payload word sends up to two bytes (its byte and the crc), a header eleven
// or twelve. A word's first byte reaches the output after passing the input
// register, the burst buffer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_record_framer_crc8 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_rec_type,
   input  wire logic [63:0] req_timestamp,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_record
);
   import srf_pkg::*;

   srf_burst_type burst;
   logic          burst_load;
   logic          burst_ready;

   // framing engine
   srf_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_rec_type  (req_rec_type),
      .req_timestamp (req_timestamp),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .burst_ready   (burst_ready),
      .burst_load    (burst_load),
      .burst         (burst)
   );

   // byte serializer
   srf_serializer u_serializer (
      .clock             (clock),
      .reset             (reset),
      .burst_load        (burst_load),
      .burst             (burst),
      .burst_ready       (burst_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_record (rsp_end_of_record)
   );

endmodule

`default_nettype wire

### tb/tb_sync_record_framer_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_record_framer_crc8 - self-checking bench for the crc-8 record framer
//
// Drives header and payload words, builds the expected byte stream of each
// record with its own framing and crc-8 logic, and compares every word leaving
// the block against it in order. A directed table covers extremes, stray
// payload, empty and abandoned records; random records follow, one of them
// running past the payload limit. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_sync_record_framer_crc8;
   import srf_pkg::*;

   localparam int PAY_LIMIT        = int'(MAX_PAYLOAD);
   localparam int RANDOM_ITEMS     = 420;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_LIMIT      = 5000;

   typedef struct packed {
      logic [7:0] octet;
      logic       eor;
   } byte_exp_type;

   // one directed word; n_typed < 0 means the frame model supplies the bytes
   typedef struct {
      logic             kind;
      logic [7:0]       rtype;
      logic [63:0]      ts;
      logic [7:0]       data;
      logic             last;
      int               n_typed;
      logic [11:0][7:0] typed_bytes;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = REQ_HEADER;
   logic [7:0]  req_rec_type = '0;
   logic [63:0] req_timestamp = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_record;

   // frame model state
   logic [7:0]  run_crc = CRC_INIT;
   logic        rec_open = 1'b0;
   int          pay_cnt = 0;

   byte_exp_type framed[$];
   byte_exp_type pending_bytes[$];
   stim_row_type directed_rows[$];
   int           errors = 0;

   sync_record_framer_crc8 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_rec_type      (req_rec_type),
      .req_timestamp     (req_timestamp),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_record (rsp_end_of_record)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // crc-8, poly 0x31, one data bit at a time msb first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic int draw_gap(input logic calm);
      return calm ? 0 : int'($urandom_range(0, 5));
   endfunction

   // trailer byte and return to the idle record state
   task automatic close_record();
      framed.push_back('{octet: run_crc, eor: 1'b1});
      rec_open = 1'b0;
      pay_cnt  = 0;
      run_crc  = CRC_INIT;
   endtask

   // bytes that one accepted word produces, left in framed
   task automatic frame_word(input logic kind, input logic [7:0] rtype,
                             input logic [63:0] ts, input logic [7:0] data,
                             input logic last);
      framed.delete();
      if (kind == REQ_HEADER) begin
         run_crc  = CRC_INIT;
         pay_cnt  = 0;
         rec_open = 1'b1;
         framed.push_back('{octet: SYNC_HI, eor: 1'b0});
         framed.push_back('{octet: SYNC_LO, eor: 1'b0});
         framed.push_back('{octet: rtype, eor: 1'b0});
         run_crc = crc8_step(run_crc, rtype);
         for (int i = 0; i < 8; i++) begin
            framed.push_back('{octet: ts[8*i +: 8], eor: 1'b0});
            run_crc = crc8_step(run_crc, ts[8*i +: 8]);
         end
         if (last) close_record();
      end else if (rec_open) begin
         // bytes past the payload limit are dropped, crc untouched
         if (pay_cnt < PAY_LIMIT) begin
            framed.push_back('{octet: data, eor: 1'b0});
            run_crc = crc8_step(run_crc, data);
            pay_cnt++;
         end
         if (last) close_record();
      end
   endtask

   task automatic add_row(input logic kind, input logic [7:0] rtype, input logic [63:0] ts,
                          input logic [7:0] data, input logic last, input int n_typed,
                          input logic [11:0][7:0] typed_bytes);
      stim_row_type r;
      r.kind        = kind;
      r.rtype       = rtype;
      r.ts          = ts;
      r.data        = data;
      r.last        = last;
      r.n_typed     = n_typed;
      r.typed_bytes = typed_bytes;
      directed_rows.push_back(r);
   endtask

   // present one word after an optional gap and wait for it to be taken
   task automatic send_word(input logic kind, input logic [7:0] rtype, input logic [63:0] ts,
                            input logic [7:0] data, input logic last, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_rec_type  <= rtype;
      req_timestamp <= ts;
      req_data_byte <= data;
      req_last      <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // send a word and queue its expected bytes, typed in or from the frame model
   task automatic issue_word(input logic kind, input logic [7:0] rtype, input logic [63:0] ts,
                             input logic [7:0] data, input logic last, input logic calm,
                             input int n_typed, input logic [11:0][7:0] typed_bytes);
      send_word(kind, rtype, ts, data, last, draw_gap(calm));
      frame_word(kind, rtype, ts, data, last);
      if (n_typed < 0) begin
         foreach (framed[i]) pending_bytes.push_back(framed[i]);
      end else begin
         for (int i = 0; i < n_typed; i++) begin
            pending_bytes.push_back('{octet: typed_bytes[i], eor: 1'b0});
         end
      end
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // stimulus
   initial begin : req_side
      stim_row_type row;
      logic        calm;
      logic        hdr_last;
      logic        abandon;
      int          npay;
      int          framed_items;
      int          drain_wait;
      logic        did_long;
      logic        did_pause;

      // directed words; typed rows carry bytes read straight off the fields
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'h5A, 1'b0, 0, '0);
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'hC3, 1'b1, 0, '0);
      add_row(REQ_HEADER, 8'h00, 64'h0, 8'h00, 1'b0, 11,
              {8'h00, {9{8'h00}}, SYNC_LO, SYNC_HI});
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'h00, 1'b0, -1, '0);
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'hFF, 1'b1, -1, '0);
      add_row(REQ_PAYLOAD, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h77, 1'b1, 0, '0);
      add_row(REQ_HEADER, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0, 11,
              {8'h00, {9{8'hFF}}, SYNC_LO, SYNC_HI});
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'h80, 1'b0, -1, '0);
      // header over an open record, closing at once
      add_row(REQ_HEADER, 8'h3C, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b1, -1, '0);
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'h01, 1'b0, 0, '0);
      add_row(REQ_HEADER, 8'h81, 64'h8000_0000_0000_0001, 8'h00, 1'b0, -1, '0);
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'hA5, 1'b0, -1, '0);
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'h5A, 1'b0, -1, '0);
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'h01, 1'b1, -1, '0);
      add_row(REQ_HEADER, 8'h7E, 64'h0000_0000_FFFF_FFFF, 8'h00, 1'b1, -1, '0);
      add_row(REQ_HEADER, 8'h00, 64'hFFFF_FFFF_0000_0000, 8'h00, 1'b0, -1, '0);
      add_row(REQ_HEADER, 8'hE7, 64'h0F0F_0F0F_0F0F_0F0F, 8'h00, 1'b0, -1, '0);
      add_row(REQ_PAYLOAD, 8'h00, 64'h0, 8'hFE, 1'b1, -1, '0);
      add_row(REQ_HEADER, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, -1, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         issue_word(row.kind, row.rtype, row.ts, row.data, row.last, 1'b0,
                    row.n_typed, row.typed_bytes);
      end

      // random records, mostly well formed
      framed_items = 0;
      did_long     = 1'b0;
      did_pause    = 1'b0;
      while (framed_items < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         if (!did_pause && framed_items >= 40) begin
            // hold the input until the output has drained
            idle_req();
            while (pending_bytes.size() != 0) @(posedge clock);
            did_pause = 1'b1;
         end
         if (!did_long && framed_items >= 80) begin
            // one record past the payload limit, closed by a dropped word
            issue_word(REQ_HEADER, 8'($urandom), rand64(), 8'($urandom), 1'b0, calm, -1, '0);
            for (int k = 1; k <= PAY_LIMIT + 3; k++) begin
               issue_word(REQ_PAYLOAD, 8'($urandom), rand64(), 8'($urandom),
                          k == PAY_LIMIT + 3, 1'b1, -1, '0);
            end
            framed_items += PAY_LIMIT + 4;
            did_long = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            // stray payload, dropped unless a record was left open
            issue_word(REQ_PAYLOAD, 8'($urandom), rand64(), 8'($urandom),
                       1'($urandom_range(0, 1)), calm, -1, '0);
         end else begin
            hdr_last = ($urandom_range(0, 7) == 0);
            issue_word(REQ_HEADER, 8'($urandom), rand64(), 8'($urandom), hdr_last, calm, -1, '0);
            framed_items++;
            if (!hdr_last) begin
               npay = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 24))
                                                   : int'($urandom_range(1, 6));
               abandon = ($urandom_range(0, 7) == 0);
               for (int k = 1; k <= npay; k++) begin
                  issue_word(REQ_PAYLOAD, 8'($urandom), rand64(), 8'($urandom),
                             k == npay && !abandon, calm, -1, '0);
               end
               framed_items += npay;
            end
         end
      end

      // drain and settle
      idle_req();
      drain_wait = 0;
      while (pending_bytes.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (12) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         errors++;
         $error("%0d expected bytes never arrived", pending_bytes.size());
      end
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // output side: random stall per word, one long hold, in-order compare
   initial begin : rsp_side
      int           hold;
      int           seen;
      logic         calm;
      byte_exp_type want;
      seen = 0;
      calm = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (seen % 32 == 0) calm = ($urandom_range(0, 3) == 0);
         hold = (seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap(calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         seen++;
         if (pending_bytes.size() == 0) begin
            errors++;
            $error("unexpected word: out_byte %h end_of_record %b",
                   rsp_out_byte, rsp_end_of_record);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.octet) begin
               errors++;
               $error("out_byte: expected %h, got %h", want.octet, rsp_out_byte);
            end
            if (rsp_end_of_record !== want.eor) begin
               errors++;
               $error("end_of_record: expected %b, got %b", want.eor, rsp_end_of_record);
            end
         end
      end
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
